### rtl/lmlt_pkg.sv
// lmlt_pkg: shared types and constants for the lcd mode and line timing unit
// no dependencies; imported by lmlt_step and lcd_mode_line_timing_unit
package lmlt_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic [3:0] CFG_OAM_SCAN = 4'd0;
    localparam logic [3:0] CFG_DRAW     = 4'd1;
    localparam logic [3:0] CFG_HBLANK   = 4'd2;
    localparam logic [3:0] CFG_LINE     = 4'd3;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;
    localparam int ACCUM_W    = 11;
    localparam logic [ACCUM_W-1:0] ACCUM_MAX = '1;

    // irq enable bits
    localparam int EN_HBLANK = 0;
    localparam int EN_VBLANK = 1;
    localparam int EN_OAM    = 2;
    localparam int EN_COINC  = 3;

    typedef struct packed {
        logic vblank_irq;
        logic stat_irq;
        logic oam_scan_trigger;
        logic line_render_trigger;
    } t_pulses;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] line;
        logic       coincidence;
        t_pulses    pulses;
    } t_result;

endpackage

### rtl/lmlt_step.sv
// lmlt_step: next-state logic for one request of the lcd mode and line timing unit
// depends on lmlt_pkg; purely combinational, state registers live in the top level
module lmlt_step #(
    parameter int VISIBLE_LINES = 144,
    parameter int LAST_LINE     = 153
) (
    input  lmlt_pkg::t_mode                    i_mode,
    input  logic [7:0]                         i_line,
    input  logic [lmlt_pkg::ACCUM_W-1:0]       i_accum,
    input  logic                               i_coinc,
    input  logic [lmlt_pkg::CFG_DATA_W-1:0]    i_oam_scan_cycles,
    input  logic [lmlt_pkg::CFG_DATA_W-1:0]    i_draw_cycles,
    input  logic [lmlt_pkg::CFG_DATA_W-1:0]    i_hblank_cycles,
    input  logic [lmlt_pkg::CFG_DATA_W-1:0]    i_line_cycles,
    input  logic [7:0]                         i_elapsed_clocks,
    input  logic                               i_lcd_on,
    input  logic [7:0]                         i_compare_line,
    input  logic [3:0]                         i_irq_enables,
    output lmlt_pkg::t_mode                    o_mode,
    output logic [7:0]                         o_line,
    output logic [lmlt_pkg::ACCUM_W-1:0]       o_accum,
    output logic                               o_coinc,
    output lmlt_pkg::t_pulses                  o_pulses
);
    import lmlt_pkg::*;

    localparam logic [7:0] VIS_LINE  = 8'(VISIBLE_LINES);
    localparam logic [7:0] LAST_L    = 8'(LAST_LINE);

    logic [ACCUM_W:0]          sum;
    logic [ACCUM_W-1:0]        sat;
    logic [CFG_DATA_W-1:0]     phase_len;
    logic                      phase_done;
    logic                      line_chg;
    logic                      mode_irq;
    t_pulses                   pulses;

    assign sum = {1'b0, i_accum} + {{(ACCUM_W + 1 - 8){1'b0}}, i_elapsed_clocks};
    assign sat = sum[ACCUM_W] ? ACCUM_MAX : sum[ACCUM_W-1:0];

    always_comb begin
        case (i_mode)
            MODE_OAM:    phase_len = i_oam_scan_cycles;
            MODE_DRAW:   phase_len = i_draw_cycles;
            MODE_HBLANK: phase_len = i_hblank_cycles;
            default:     phase_len = i_line_cycles;
        endcase
    end

    assign phase_done = sat >= {{(ACCUM_W - CFG_DATA_W){1'b0}}, phase_len};

    always_comb begin
        o_mode   = i_mode;
        o_line   = i_line;
        o_accum  = sat;
        o_coinc  = i_coinc;
        pulses   = '0;
        line_chg = 1'b0;
        if (!i_lcd_on) begin
            o_mode  = MODE_HBLANK;
            o_line  = '0;
            o_accum = '0;
        end else if (phase_done) begin
            o_accum = sat - {{(ACCUM_W - CFG_DATA_W){1'b0}}, phase_len};
            case (i_mode)
                MODE_OAM: begin
                    o_mode = MODE_DRAW;
                    pulses.oam_scan_trigger = 1'b1;
                end
                MODE_DRAW: begin
                    o_mode = MODE_HBLANK;
                    pulses.line_render_trigger = 1'b1;
                end
                MODE_HBLANK: begin
                    o_line   = i_line + 8'd1;
                    line_chg = 1'b1;
                    if (o_line == VIS_LINE) begin
                        o_mode = MODE_VBLANK;
                        pulses.vblank_irq = 1'b1;
                    end else begin
                        o_mode = MODE_OAM;
                    end
                end
                default: begin
                    line_chg = 1'b1;
                    if (i_line < LAST_L) begin
                        o_line = i_line + 8'd1;
                    end else begin
                        o_line = '0;
                        o_mode = MODE_OAM;
                    end
                end
            endcase
        end
        if (line_chg) begin
            o_coinc = (o_line == i_compare_line);
        end
    end

    // mode interrupt only on an actual change of mode
    always_comb begin
        mode_irq = 1'b0;
        if (o_mode != i_mode) begin
            case (o_mode)
                MODE_HBLANK: mode_irq = i_irq_enables[EN_HBLANK];
                MODE_VBLANK: mode_irq = i_irq_enables[EN_VBLANK];
                MODE_OAM:    mode_irq = i_irq_enables[EN_OAM];
                default:     mode_irq = 1'b0;
            endcase
        end
    end

    always_comb begin
        o_pulses          = pulses;
        o_pulses.stat_irq = mode_irq
                          || (line_chg && o_coinc && i_irq_enables[EN_COINC]);
    end

endmodule

### rtl/lcd_mode_line_timing_unit.sv
// lcd mode and scanline timing unit, top level
// a request's result is registered: it goes into the result register, or into the skid register while a result is held
// throughput: one request per cycle; a two-entry output stage (result plus skid register)
// lets requests keep coming while one result waits, o_stall rises only when both are full
// reset: synchronous active-low; mode hblank, line 0, count 0, coincidence 0,
// phase lengths 80/172/204/456, output stage empty
module lcd_mode_line_timing_unit #(
    parameter int VISIBLE_LINES = 144,
    parameter int LAST_LINE     = 153
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lmlt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lmlt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_elapsed_clocks,
    input  logic                                i_lcd_on,
    input  logic [7:0]                          i_compare_line,
    input  logic [3:0]                          i_irq_enables,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_lcd_mode,
    output logic [7:0]                          o_line_number,
    output logic                                o_coincidence,
    output logic                                o_vblank_irq,
    output logic                                o_stat_irq,
    output logic                                o_oam_scan_trigger,
    output logic                                o_line_render_trigger
);
    import lmlt_pkg::*;

    logic [CFG_DATA_W-1:0] r_oam_scan_cycles, r_draw_cycles, r_hblank_cycles, r_line_cycles;

    t_mode               r_mode, n_mode;
    logic [7:0]          r_line, n_line;
    logic [ACCUM_W-1:0]  r_accum, n_accum;
    logic                r_coinc, n_coinc;
    t_pulses             step_pulses;

    t_result             r_out, n_out, r_skid, n_skid, new_res;
    logic                r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;
    logic                in_acc, out_take;

    assign in_acc   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oam_scan_cycles <= CFG_DATA_W'(80);
            r_draw_cycles     <= CFG_DATA_W'(172);
            r_hblank_cycles   <= CFG_DATA_W'(204);
            r_line_cycles     <= CFG_DATA_W'(456);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OAM_SCAN: r_oam_scan_cycles <= i_cfg_data;
                CFG_DRAW:     r_draw_cycles     <= i_cfg_data;
                CFG_HBLANK:   r_hblank_cycles   <= i_cfg_data;
                CFG_LINE:     r_line_cycles     <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    lmlt_step #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .LAST_LINE     (LAST_LINE)
    ) u_step (
        .i_mode            (r_mode),
        .i_line            (r_line),
        .i_accum           (r_accum),
        .i_coinc           (r_coinc),
        .i_oam_scan_cycles (r_oam_scan_cycles),
        .i_draw_cycles     (r_draw_cycles),
        .i_hblank_cycles   (r_hblank_cycles),
        .i_line_cycles     (r_line_cycles),
        .i_elapsed_clocks  (i_elapsed_clocks),
        .i_lcd_on          (i_lcd_on),
        .i_compare_line    (i_compare_line),
        .i_irq_enables     (i_irq_enables),
        .o_mode            (n_mode),
        .o_line            (n_line),
        .o_accum           (n_accum),
        .o_coinc           (n_coinc),
        .o_pulses          (step_pulses)
    );

    always_comb begin
        new_res.mode        = n_mode;
        new_res.line        = n_line;
        new_res.coincidence = n_coinc;
        new_res.pulses      = step_pulses;
    end

    // timing state advances on every accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HBLANK;
            r_line  <= '0;
            r_accum <= '0;
            r_coinc <= 1'b0;
        end else if (in_acc) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_accum <= n_accum;
            r_coinc <= n_coinc;
        end
    end

    // output stage: result register backed by one skid register
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (in_acc) begin
                n_out       = new_res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_acc) begin
            n_skid       = new_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_stall               = r_skid_valid;
    assign o_valid               = r_out_valid;
    assign o_lcd_mode            = r_out.mode;
    assign o_line_number         = r_out.line;
    assign o_coincidence         = r_out.coincidence;
    assign o_vblank_irq          = r_out.pulses.vblank_irq;
    assign o_stat_irq            = r_out.pulses.stat_irq;
    assign o_oam_scan_trigger    = r_out.pulses.oam_scan_trigger;
    assign o_line_render_trigger = r_out.pulses.line_render_trigger;

    // skid register only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register valid without a held result");

    a_oam_trig_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_oam_scan_trigger) |-> (o_lcd_mode == MODE_DRAW))
        else $error("oam scan trigger outside drawing mode");

    a_render_trig_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_render_trigger) |-> (o_lcd_mode == MODE_HBLANK))
        else $error("line render trigger outside hblank");

    a_vblank_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_vblank_irq) |->
            (o_lcd_mode == MODE_VBLANK && o_line_number == 8'(VISIBLE_LINES)))
        else $error("vblank pulse away from the first vblank line");

    // a held result stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_out)))
        else $error("held result changed under stall");

endmodule
